@@ src/hcpg_pkg.sv @@
// ---------------------------------------------------------------------------
// hcpg_pkg: shared types and constants of the Hermite curve point generator
// Request layout, controller command and status, Horner term and axis codes.
// ---------------------------------------------------------------------------
package hcpg_pkg;

   localparam int IN_W        = 16;  // point and tangent components
   localparam int STEPS_W     = 7;
   localparam int COLOR_W     = 24;
   localparam int COORD_BITS  = 16;  // saturated output coordinate
   localparam int COEF_W      = 20;  // holds c2 (up to 9 * 2^15) and c3
   localparam int INT_W       = 22;  // integer part of the Horner accumulator
   localparam int REQ_TDATA_W = 160;
   localparam int RSP_TDATA_W = 56;

   // first member is the most significant: x_start lands in the low bits
   typedef struct packed {
      logic [COLOR_W-1:0]      color;
      logic [STEPS_W-1:0]      steps;
      logic signed [IN_W-1:0]  y_tangent_end;
      logic signed [IN_W-1:0]  x_tangent_end;
      logic signed [IN_W-1:0]  y_end;
      logic signed [IN_W-1:0]  x_end;
      logic signed [IN_W-1:0]  y_tangent_start;
      logic signed [IN_W-1:0]  x_tangent_start;
      logic signed [IN_W-1:0]  y_start;
      logic signed [IN_W-1:0]  x_start;
   } hcpg_req_type;

   localparam int REQ_W = $bits(hcpg_req_type);

   typedef enum logic [1:0] {
      TERM_C2 = 2'd0,
      TERM_C1 = 2'd1,
      TERM_C0 = 2'd2
   } hcpg_term_type;

   typedef enum logic {
      AXIS_X = 1'b0,
      AXIS_Y = 1'b1
   } hcpg_axis_type;

   typedef struct packed {
      logic          load;      // capture request, compute coefficients
      logic          div_step;  // one quotient bit of t
      logic          h_init;    // h = c3 * 2^F
      logic          mul_lo;    // product of low fraction and t
      logic          mul_hi;    // product of integer part and t
      logic          acc;       // add partial products and next term
      hcpg_term_type term;
      hcpg_axis_type axis;
      logic          round;     // round and saturate into the axis result
      logic          emit;      // load output register, advance k
   } hcpg_cmd_type;

   typedef struct packed {
      logic out_free;
      logic last_point;
   } hcpg_sts_type;

endpackage

@@ src/hcpg_ctrl.sv @@
// ---------------------------------------------------------------------------
// hcpg_ctrl: sequencer of the Hermite curve point generator
// Steps the divider, then three Horner steps per axis, then hands off a point.
// ---------------------------------------------------------------------------
module hcpg_ctrl #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output hcpg_pkg::hcpg_cmd_type cmd,
   input  hcpg_pkg::hcpg_sts_type sts
);
   import hcpg_pkg::*;

   localparam int CNT_W = $clog2(FRACTION_BITS);

   typedef enum logic [2:0] {
      S_IDLE, S_DIV, S_INIT, S_MLO, S_MHI, S_ACC, S_RND, S_OUT
   } state_type;

   state_type     state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   hcpg_term_type term_ff, term_in;
   hcpg_axis_type axis_ff, axis_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      term_in  = term_ff;
      axis_in  = axis_ff;
      cmd      = '0;
      cmd.term = term_ff;
      cmd.axis = axis_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(FRACTION_BITS - 1)) begin
               axis_in  = AXIS_X;
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            cmd.h_init = 1'b1;
            term_in    = TERM_C2;
            state_in   = S_MLO;
         end
         S_MLO: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_MHI;
         end
         S_MHI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_ACC;
         end
         S_ACC: begin
            cmd.acc = 1'b1;
            if (term_ff == TERM_C0) begin
               state_in = S_RND;
            end else begin
               term_in  = (term_ff == TERM_C2) ? TERM_C1 : TERM_C0;
               state_in = S_MLO;
            end
         end
         S_RND: begin
            cmd.round = 1'b1;
            if (axis_ff == AXIS_X) begin
               axis_in  = AXIS_Y;
               state_in = S_INIT;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cnt_in   = '0;
               state_in = sts.last_point ? S_IDLE : S_DIV;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         term_ff  <= TERM_C2;
         axis_ff  <= AXIS_X;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         term_ff  <= term_in;
         axis_ff  <= axis_in;
      end
   end

endmodule

@@ src/hcpg_datapath.sv @@
// ---------------------------------------------------------------------------
// hcpg_datapath: arithmetic of the Hermite curve point generator
// Coefficients, bit-serial t divider, shared Horner multiplier, output register.
// ---------------------------------------------------------------------------
module hcpg_datapath #(
   parameter int MAX_STEPS     = 64,
   parameter int FRACTION_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hcpg_pkg::hcpg_cmd_type        cmd,
   output hcpg_pkg::hcpg_sts_type        sts,
   input  hcpg_pkg::hcpg_req_type        req_item,
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   output logic                          rsp_tlast,
   output logic signed [hcpg_pkg::COORD_BITS-1:0] point_x,
   output logic signed [hcpg_pkg::COORD_BITS-1:0] point_y,
   output logic [hcpg_pkg::COLOR_W-1:0]  point_color
);
   import hcpg_pkg::*;

   localparam int F  = FRACTION_BITS;
   localparam int HW = INT_W + F;
   localparam int AW = (INT_W > F + 1) ? INT_W : F + 1;
   localparam int PW = AW + F + 1;
   localparam int KW = $clog2(MAX_STEPS + 1);
   localparam logic signed [HW-1:0] HALF = HW'(64'd1 << (F - 1));
   localparam logic signed [INT_W-1:0] SAT_HI = INT_W'((64'd1 << (COORD_BITS - 1)) - 1);
   localparam logic signed [INT_W-1:0] SAT_LO = -SAT_HI - INT_W'(1);

   function automatic logic signed [COEF_W-1:0] coef2(
      input logic signed [IN_W-1:0] p0, t0, p1, t1);
      logic signed [COEF_W-1:0] a, b, c, d;
      a = COEF_W'(p0);
      b = COEF_W'(t0);
      c = COEF_W'(p1);
      d = COEF_W'(t1);
      return (c + (c <<< 1)) - (a + (a <<< 1)) - (b <<< 1) - d;
   endfunction

   function automatic logic signed [COEF_W-1:0] coef3(
      input logic signed [IN_W-1:0] p0, t0, p1, t1);
      logic signed [COEF_W-1:0] a, b, c, d;
      a = COEF_W'(p0);
      b = COEF_W'(t0);
      c = COEF_W'(p1);
      d = COEF_W'(t1);
      return (a <<< 1) + b - (c <<< 1) + d;
   endfunction

   // per-axis curve data, index 0 is x
   logic signed [IN_W-1:0]   p0_ff [2];
   logic signed [IN_W-1:0]   t0_ff [2];
   logic signed [COEF_W-1:0] c2_ff [2];
   logic signed [COEF_W-1:0] c3_ff [2];
   logic [COLOR_W-1:0]       color_ff;
   logic [KW-1:0]            n_ff, k_ff;
   logic [KW:0]              rem_ff;
   logic [F-1:0]             q_ff;
   logic signed [HW-1:0]     h_ff;
   logic signed [PW-1:0]     prod_ff;
   logic [F-1:0]             frac_ff;
   logic signed [COORD_BITS-1:0] px_ff, py_ff;
   logic signed [COORD_BITS-1:0] out_x_ff, out_y_ff;
   logic [COLOR_W-1:0]       out_color_ff;
   logic                     out_last_ff, out_valid_ff;

   logic [KW-1:0]            n_clamp, k_next;
   logic [KW:0]              rem_dbl;
   logic                     rem_ge;
   logic signed [AW-1:0]     mul_a;
   logic signed [F:0]        mul_b;
   logic signed [PW-1:0]     mul_p;
   logic signed [COEF_W-1:0] term_val;
   logic signed [HW-1:0]     term_sh, acc_sum, rnd_sum;
   logic signed [INT_W-1:0]  rnd_int;
   logic signed [COORD_BITS-1:0] sat_val;

   // clamp the step count to 1..MAX_STEPS
   always_comb begin
      priority if (req_item.steps == '0) begin
         n_clamp = KW'(1);
      end else if (req_item.steps > STEPS_W'(MAX_STEPS)) begin
         n_clamp = KW'(MAX_STEPS);
      end else begin
         n_clamp = KW'(req_item.steps);
      end
   end

   assign k_next  = k_ff + KW'(1);
   assign rem_dbl = {rem_ff[KW-1:0], 1'b0};
   assign rem_ge  = rem_dbl >= {1'b0, n_ff};

   // shared multiplier: unsigned low fraction or signed integer part, times t
   assign mul_a = cmd.mul_lo ? AW'($signed({1'b0, h_ff[F-1:0]}))
                             : AW'($signed(h_ff[HW-1:F]));
   assign mul_b = $signed({1'b0, q_ff});
   assign mul_p = mul_a * mul_b;

   always_comb begin
      unique case (cmd.term)
         TERM_C2: term_val = c2_ff[cmd.axis];
         TERM_C1: term_val = COEF_W'(t0_ff[cmd.axis]);
         TERM_C0: term_val = COEF_W'(p0_ff[cmd.axis]);
         default: term_val = COEF_W'(p0_ff[cmd.axis]);
      endcase
   end

   assign term_sh = {INT_W'(term_val), {F{1'b0}}};
   assign acc_sum = HW'(prod_ff) + HW'($signed({1'b0, frac_ff})) + term_sh;
   assign rnd_sum = h_ff + HALF;
   assign rnd_int = rnd_sum[HW-1:F];

   always_comb begin
      priority if (rnd_int > SAT_HI) begin
         sat_val = COORD_BITS'(SAT_HI);
      end else if (rnd_int < SAT_LO) begin
         sat_val = COORD_BITS'(SAT_LO);
      end else begin
         sat_val = COORD_BITS'(rnd_int);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         p0_ff[0] <= req_item.x_start;
         p0_ff[1] <= req_item.y_start;
         t0_ff[0] <= req_item.x_tangent_start;
         t0_ff[1] <= req_item.y_tangent_start;
         c2_ff[0] <= coef2(req_item.x_start, req_item.x_tangent_start,
                           req_item.x_end, req_item.x_tangent_end);
         c2_ff[1] <= coef2(req_item.y_start, req_item.y_tangent_start,
                           req_item.y_end, req_item.y_tangent_end);
         c3_ff[0] <= coef3(req_item.x_start, req_item.x_tangent_start,
                           req_item.x_end, req_item.x_tangent_end);
         c3_ff[1] <= coef3(req_item.y_start, req_item.y_tangent_start,
                           req_item.y_end, req_item.y_tangent_end);
         color_ff <= req_item.color;
         n_ff     <= n_clamp;
         k_ff     <= '0;
         rem_ff   <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= rem_ge ? rem_dbl - {1'b0, n_ff} : rem_dbl;
         q_ff   <= {q_ff[F-2:0], rem_ge};
      end
      if (cmd.h_init) begin
         h_ff <= {INT_W'(c3_ff[cmd.axis]), {F{1'b0}}};
      end
      if (cmd.mul_lo) begin
         prod_ff <= mul_p;
      end
      if (cmd.mul_hi) begin
         frac_ff <= prod_ff[2*F-1:F];
         prod_ff <= mul_p;
      end
      if (cmd.acc) begin
         h_ff <= acc_sum;
      end
      if (cmd.round) begin
         if (cmd.axis == AXIS_X) begin
            px_ff <= sat_val;
         end else begin
            py_ff <= sat_val;
         end
      end
      if (cmd.emit) begin
         out_x_ff     <= px_ff;
         out_y_ff     <= py_ff;
         out_color_ff <= color_ff;
         out_last_ff  <= (k_next == n_ff);
         k_ff         <= k_next;
         rem_ff       <= {1'b0, k_next};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign sts.out_free   = !out_valid_ff || rsp_tready;
   assign sts.last_point = (k_next == n_ff);

   assign rsp_tvalid  = out_valid_ff;
   assign rsp_tlast   = out_last_ff;
   assign point_x     = out_x_ff;
   assign point_y     = out_y_ff;
   assign point_color = out_color_ff;

endmodule

@@ src/hermite_curve_point_generator_unit.sv @@
// The one-bit-per-cycle divider for t and the single shared multiplier set the
//   pace; the multiplier runs three Horner steps of two products each per axis.
// A new request is taken only after the previous request's final point is handed off.
// Reset: synchronous, active high; clears the sequencer and the output valid.
// ---------------------------------------------------------------------------
// hermite_curve_point_generator_unit: cubic Hermite curve point generator
// Takes one 2D Hermite segment per request and streams its points, each at
// t = floor(k * 2^F / steps), evaluated by Horner in fixed point, rounded
// half up and saturated to 16-bit signed, with the color passed through.
// ---------------------------------------------------------------------------
module hermite_curve_point_generator_unit #(
   parameter int MAX_STEPS     = 64,  // 1 to 64
   parameter int FRACTION_BITS = 16   // 8 to 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // x_start[15:0], y_start[31:16], x_tangent_start[47:32],
   // y_tangent_start[63:48], x_end[79:64], y_end[95:80],
   // x_tangent_end[111:96], y_tangent_end[127:112], steps[134:128],
   // color[158:135], zero pad[159]
   input  logic [hcpg_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // point_x[15:0], point_y[31:16], point_color[55:32]
   output logic [hcpg_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready
);
   import hcpg_pkg::*;

   hcpg_cmd_type             cmd;
   hcpg_sts_type             sts;
   hcpg_req_type             req_item;
   logic signed [COORD_BITS-1:0] point_x, point_y;
   logic [COLOR_W-1:0]       point_color;

   // unpack the request; the pad bit above the color is dropped
   assign req_item = hcpg_req_type'(req_tdata[REQ_W-1:0]);

   // sequencer: idle, divide for t, Horner per axis, hand off the point
   hcpg_ctrl #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // datapath: coefficients, divider, shared multiplier, output register.
   // The output register lets the next point (or the next request) proceed
   // while the previous point waits for the downstream side.
   hcpg_datapath #(
      .MAX_STEPS     (MAX_STEPS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_item    (req_item),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tlast   (rsp_tlast),
      .point_x     (point_x),
      .point_y     (point_y),
      .point_color (point_color)
   );

   // pack the result; the fields fill 56 bits exactly
   assign rsp_tdata = {point_color, point_y, point_x};

   // a taken request keeps the unit busy for at least the divider pass
   a_busy_after_req : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous curve still in progress");

   // a point is only loaded when the output register can take it
   a_emit_room : assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("point loaded over an unaccepted result");

   // handing off the final point returns the unit to idle
   a_idle_after_last : assert property (@(posedge clock) disable iff (reset)
      cmd.emit && sts.last_point |=> req_tready && rsp_tvalid && rsp_tlast)
      else $error("unit not idle after the final point");

endmodule
